// ===== src/whist_pkg.sv =====
// Package for the weighted histogram accumulator.
// Holds store sizes, field widths, item kind and status codes, and the adder result type.
// No dependencies.
package whist_pkg;

  // Store size and derived address width.
  localparam int unsigned MaxBins      = 1024;
  localparam int unsigned BinAddrW     = (MaxBins > 1) ? $clog2(MaxBins) : 1;

  // Field widths.
  localparam int unsigned KindW        = 2;
  localparam int unsigned BinNumberW   = 16;
  localparam int unsigned WeightW      = 32;
  localparam int unsigned SumW         = 48;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned BinCountW    = 11;

  // Weights and sums share this many fractional bits, so no alignment shift is needed.
  localparam int unsigned WeightFracBits = 16;

  localparam logic [BinCountW-1:0] BinCountReset = BinCountW'(1024);

  // Item kinds.
  localparam logic [KindW-1:0] KIND_ACC    = 2'd0;
  localparam logic [KindW-1:0] KIND_READ   = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RANGE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   saturated;
  } acc_result_t;

endpackage

// ===== src/whist_if.sv =====
// Stream interfaces for the weighted histogram accumulator.
// One interface per channel; depends on whist_pkg.
interface whist_in_if
  import whist_pkg::*;
  ;
  logic                          valid;
  logic                          ready;
  logic        [KindW-1:0]       kind;
  logic        [BinNumberW-1:0]  bin_number;
  logic signed [WeightW-1:0]     weight;

  modport source (output valid, kind, bin_number, weight, input ready);
  modport sink   (input valid, kind, bin_number, weight, output ready);
endinterface

interface whist_out_if
  import whist_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic signed [SumW-1:0]     bin_sum;
  logic        [StatusW-1:0]  status;

  modport source (output valid, bin_sum, status, input ready);
  modport sink   (input valid, bin_sum, status, output ready);
endinterface

// ===== src/whist_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module whist_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/whist_acc.sv =====
// Saturating adder: adds a sign-extended weight to a bin sum, clamping at the sum limits.
// Depends on whist_pkg.
module whist_acc
  import whist_pkg::*;
(
  input  logic signed [SumW-1:0]    sum_i,
  input  logic signed [WeightW-1:0] weight_i,
  output acc_result_t               result_o
);

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  logic signed [SumW:0] wide_sum;

  assign wide_sum = (SumW+1)'(sum_i) + (SumW+1)'(weight_i);

  always_comb begin
    result_o.saturated = (wide_sum[SumW] != wide_sum[SumW-1]);
    if (!result_o.saturated) begin
      result_o.sum = wide_sum[SumW-1:0];
    end else if (wide_sum[SumW]) begin
      result_o.sum = SumMin;
    end else begin
      result_o.sum = SumMax;
    end
  end

endmodule

// ===== src/weighted_histogram_accumulator.sv =====
// Top level of the weighted histogram accumulator.
// Depends on whist_pkg, whist_if, whist_ram and whist_acc.

// The block holds MaxBins signed 48-bit bin sums (Q32.16) in one synchronous RAM and
// answers every input transaction with exactly one output transaction. An accumulate
// transaction adds a signed Q16.16 weight to the bin named by its 1-based bin number and
// returns the new sum, saturating at the 48-bit limits with status 2; a read transaction
// returns the bin's sum; a bin number of zero or above the smaller of the configured bin
// count and the store size is ignored and answered with a zero sum and status 1. The bin
// is read from the RAM in the accept cycle and the sum is added and written back in the
// next, and the input is not ready during that cycle, so the read-modify-write of the single
// RAM is through before a new transaction is taken. Because only one transaction is in
// flight, a write back can never race a read of the same bin. The store is emptied by a
// clearing pass that writes zero to each bin, one per cycle: it runs right after reset
// and after every clear transaction, and no input transaction is accepted while it runs.
// The clear transaction's own answer (zero sum, status 0) is posted before the pass ends.
// The bin_count register may be written at any idle time and only limits which bin
// numbers are valid; stored sums are kept across a change.
module weighted_histogram_accumulator
  import whist_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [BinCountW-1:0]  cfg_wdata_i,
  whist_in_if.sink              in_i,
  whist_out_if.source           out_o
);

  localparam int unsigned             RangeW     = BinNumberW + 1;
  localparam logic [RangeW-1:0]       MaxBinsV   = RangeW'(MaxBins);
  localparam logic [BinAddrW-1:0]     LastAddr   = BinAddrW'(MaxBins - 1);

  // Configuration register.
  logic [BinCountW-1:0] bin_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= BinCountReset;
    end else if (cfg_we_i) begin
      bin_count_q <= cfg_wdata_i;
    end
  end

  // Clearing pass control. The pass starts active out of reset.
  logic                clr_active_q, clr_active_d;
  logic [BinAddrW-1:0] clr_addr_q, clr_addr_d;

  // Stage register for the transaction whose bin is being read.
  logic                        busy_q;
  logic [KindW-1:0]            st_kind_q;
  logic [BinAddrW-1:0]         st_addr_q;
  logic signed [WeightW-1:0]   st_weight_q;
  logic                        st_in_range_q;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic signed [SumW-1:0]      out_sum_q, out_sum_d;
  logic [StatusW-1:0]          out_status_q, out_status_d;

  logic                        in_accept;
  logic                        in_range;
  logic [BinNumberW-1:0]       bin_index;
  logic [SumW-1:0]             ram_rdata;
  logic                        ram_we;
  logic [BinAddrW-1:0]         ram_waddr;
  logic [SumW-1:0]             ram_wdata;
  acc_result_t                 acc_res;

  // The input is taken only when nothing is in flight, no clearing pass runs and the
  // output register is free or being emptied in this cycle.
  assign in_i.ready = !busy_q && !clr_active_q && (!out_valid_q || out_o.ready);
  assign in_accept  = in_i.valid && in_i.ready;

  // A bin number is valid from 1 up to the smaller of bin_count and the store size.
  assign in_range = (in_i.bin_number != '0)
                 && (RangeW'(in_i.bin_number) <= RangeW'(bin_count_q))
                 && (RangeW'(in_i.bin_number) <= MaxBinsV);

  assign bin_index = in_i.bin_number - BinNumberW'(1);

  whist_ram #(
    .Depth (MaxBins),
    .Width (SumW),
    .AddrW (BinAddrW)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (bin_index[BinAddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  whist_acc u_acc (
    .sum_i    (ram_rdata),
    .weight_i (st_weight_q),
    .result_o (acc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      st_kind_q     <= in_i.kind;
      st_addr_q     <= bin_index[BinAddrW-1:0];
      st_weight_q   <= in_i.weight;
      st_in_range_q <= in_range;
    end
  end

  // With a transaction in flight (busy_q): form the answer and, for an accumulate, the write back.
  // The clearing pass owns the write port otherwise; the two never overlap.
  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_q;
    ram_wdata    = '0;

    if (clr_active_q) begin
      ram_we     = 1'b1;
      clr_addr_d = clr_addr_q + BinAddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_active_d = 1'b0;
      end
    end

    if (busy_q) begin
      out_valid_d  = 1'b1;
      out_sum_d    = '0;
      out_status_d = STATUS_OK;
      unique case (st_kind_q)
        KIND_CLEAR: begin
          clr_active_d = 1'b1;
          clr_addr_d   = '0;
        end
        KIND_UNUSED: begin
          // Changes nothing and answers a zero sum.
        end
        KIND_READ: begin
          if (st_in_range_q) begin
            out_sum_d = ram_rdata;
          end else begin
            out_status_d = STATUS_RANGE;
          end
        end
        KIND_ACC: begin
          if (st_in_range_q) begin
            ram_we       = 1'b1;
            ram_waddr    = st_addr_q;
            ram_wdata    = acc_res.sum;
            out_sum_d    = acc_res.sum;
            out_status_d = acc_res.saturated ? STATUS_SAT : STATUS_OK;
          end else begin
            out_status_d = STATUS_RANGE;
          end
        end
        default: begin
          out_status_d = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.bin_sum = out_sum_q;
  assign out_o.status  = out_status_q;

endmodule
